/* hdl/shift_array_list_engine_unit_defines.svh */
// Assertion macros for the shift array list engine checker.
// Needs a clock named clock and a reset named reset in the using scope.
`ifndef SHIFT_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH
`define SHIFT_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH

// Clocked check, switched off while reset is high.
`define SALE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SALE_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hdl/sale_pkg.sv */
// Shared constants, codes, command struct and helpers for the list engine.
// No dependencies; every other file in hdl but the defines header uses it by scoped names.
`timescale 1ns / 1ps

package sale_pkg;

   localparam int DEPTH       = 128;
   localparam int DATA_W      = 32;

   localparam int FUNC_W      = 3;
   localparam int POS_W       = 7;
   localparam int VALUE_W     = 32;
   localparam int DOUT_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 8;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;

   // read-back taps are OR-ed in groups, then across groups
   localparam int GRP_SIZE = 16;
   localparam int GROUPS   = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;

   localparam logic [CNT_W-1:0]       FULL_COUNT     = CNT_W'(DEPTH);
   localparam logic [COUNT_OUT_W-1:0] FULL_COUNT_OUT = COUNT_OUT_W'(DEPTH);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND     = 3'd0,
      FUNC_PUSH_FRONT = 3'd1,
      FUNC_INSERT     = 3'd2,
      FUNC_ERASE      = 3'd3,
      FUNC_READ       = 3'd4
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // broadcast to every cell in the row
   typedef struct packed {
      logic              ins;
      logic              del;
      logic              rd_en;
      logic [CMP_W-1:0]  at;
      logic [CMP_W-1:0]  rd_idx;
      logic [DATA_W-1:0] din;
   } cmd_type;

   function automatic logic [DATA_W-1:0] fit_data(input logic [VALUE_W-1:0] v);
      logic [DATA_W-1:0] r;
      r = '0;
      for (int b = 0; b < DATA_W; b++) begin
         if (b < VALUE_W) r[b] = v[b];
      end
      return r;
   endfunction

   function automatic logic [DOUT_W-1:0] to_dout(input logic [DATA_W-1:0] v);
      logic [DOUT_W-1:0] r;
      r = '0;
      for (int b = 0; b < DOUT_W; b++) begin
         if (b < DATA_W) r[b] = v[b];
      end
      return r;
   endfunction

   function automatic logic [COUNT_OUT_W-1:0] to_count_out(input logic [CNT_W-1:0] v);
      logic [COUNT_OUT_W-1:0] r;
      r = '0;
      for (int b = 0; b < COUNT_OUT_W; b++) begin
         if (b < CNT_W) r[b] = v[b];
      end
      return r;
   endfunction

endpackage

/* hdl/sale_req_if.sv */
// Request channel: valid/ready handshake carrying one list operation.
// Depends on sale_pkg for field widths.
`timescale 1ns / 1ps

interface sale_req_if;
   logic                        valid;
   logic                        ready;
   logic [sale_pkg::FUNC_W-1:0]  func;
   logic [sale_pkg::POS_W-1:0]   position;
   logic [sale_pkg::VALUE_W-1:0] value;

   modport source (output valid, func, position, value, input ready);
   modport sink   (input valid, func, position, value, output ready);
endinterface

/* hdl/sale_rsp_if.sv */
// Response channel: valid/ready handshake carrying one operation result.
// Depends on sale_pkg for field widths.
`timescale 1ns / 1ps

interface sale_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sale_pkg::DOUT_W-1:0]      data_out;
   logic [sale_pkg::STATUS_W-1:0]    status;
   logic [sale_pkg::COUNT_OUT_W-1:0] count_out;
   logic                            at_end;

   modport source (output valid, data_out, status, count_out, at_end, input ready);
   modport sink   (input valid, data_out, status, count_out, at_end, output ready);
endinterface

/* hdl/sale_cell.sv */
// One storage cell of the list row: loads from its left or right neighbour,
// the request value, or holds. Depends on sale_pkg.
`timescale 1ns / 1ps

module sale_cell (
   input  logic                           clock,
   input  sale_pkg::cmd_type              cmd,
   input  logic [sale_pkg::CMP_W-1:0]     idx,
   input  logic [sale_pkg::DATA_W-1:0]    left_data,
   input  logic [sale_pkg::DATA_W-1:0]    right_data,
   output logic [sale_pkg::DATA_W-1:0]    data_q,
   output logic [sale_pkg::DATA_W-1:0]    tap
);

   logic [sale_pkg::DATA_W-1:0] data_ff;
   logic [sale_pkg::DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      priority if (cmd.ins) begin
         // open a gap: everything above the slot moves up one
         if (idx > cmd.at)       data_in = left_data;
         else if (idx == cmd.at) data_in = cmd.din;
      end else if (cmd.del) begin
         // close the gap: the slot and everything above take the next entry
         if (idx >= cmd.at)      data_in = right_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;
   assign tap    = (cmd.rd_en && idx == cmd.rd_idx) ? data_ff : '0;

endmodule

/* hdl/shift_array_list_engine_unit.sv */
// Top level of the shift array list engine: a row of sale_cell instances,
// operation decode, entry count and a two-stage result path.
// Depends on sale_pkg, sale_req_if, sale_rsp_if and sale_cell.
//
//   channel   | direction | handshake   | payload
//   ----------+-----------+-------------+-----------------------------------
//   req_chan  | in        | valid/ready | func, position, value
//   rsp_chan  | out       | valid/ready | data_out, status, count_out, at_end
//
// One transaction per cycle sustained while the response is not stalled; each result
// passes through the first-stage registers and then the output register. The cell
// row shifts in the accepting cycle; the first stage registers the OR of the cell
// read taps within each group, and the output register takes the OR across groups.
// Reset clears the entry count and empties both result stages; cell contents
// are not cleared. A stalled response holds the result and the stage behind it;
// req_ready is low during reset and when both stages are full with rsp stalled.
`timescale 1ns / 1ps

module shift_array_list_engine_unit (
   input  logic        clock,
   input  logic        reset,
   sale_req_if.sink    req_chan,
   sale_rsp_if.source  rsp_chan
);

   localparam int DEPTH    = sale_pkg::DEPTH;
   localparam int DATA_W   = sale_pkg::DATA_W;
   localparam int CNT_W    = sale_pkg::CNT_W;
   localparam int CMP_W    = sale_pkg::CMP_W;
   localparam int GRP_SIZE = sale_pkg::GRP_SIZE;
   localparam int GROUPS   = sale_pkg::GROUPS;

   sale_pkg::cmd_type   cmd;
   logic [DATA_W-1:0]   cell_q  [DEPTH];
   logic [DATA_W-1:0]   taps    [DEPTH];
   logic [DATA_W-1:0]   left_w  [DEPTH];
   logic [DATA_W-1:0]   right_w [DEPTH];

   logic                fire;
   logic                s2_free;
   logic                s1_move;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CMP_W-1:0]    pos_x, cnt_x;
   logic                ins_w, del_w;
   sale_pkg::status_type status_in;
   logic                at_end_in;

   logic                s1_valid_ff;
   logic [DATA_W-1:0]   part_ff [GROUPS];
   logic [DATA_W-1:0]   part_in [GROUPS];
   sale_pkg::status_type s1_status_ff;
   logic [CNT_W-1:0]    s1_count_ff;
   logic                s1_at_end_ff;

   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   sale_pkg::status_type rsp_status_ff;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic                rsp_at_end_ff;

   assign s2_free        = !rsp_valid_ff || rsp_chan.ready;
   assign s1_move        = s1_valid_ff && s2_free;
   assign req_chan.ready = !reset && (!s1_valid_ff || s2_free);
   assign fire           = req_chan.valid && req_chan.ready;

   assign pos_x = CMP_W'(req_chan.position);
   assign cnt_x = CMP_W'(count_ff);

   // decode the operation against the current count
   always_comb begin
      ins_w        = 1'b0;
      del_w        = 1'b0;
      cmd.rd_en    = 1'b0;
      cmd.at       = '0;
      cmd.rd_idx   = pos_x;
      cmd.din      = sale_pkg::fit_data(req_chan.value);
      status_in    = sale_pkg::ST_OK;
      at_end_in    = 1'b0;
      count_in     = count_ff;
      unique case (sale_pkg::func_type'(req_chan.func))
         sale_pkg::FUNC_APPEND: begin
            if (count_ff == sale_pkg::FULL_COUNT) status_in = sale_pkg::ST_FULL;
            else begin
               ins_w  = 1'b1;
               cmd.at = cnt_x;
            end
         end
         sale_pkg::FUNC_PUSH_FRONT: begin
            if (count_ff == sale_pkg::FULL_COUNT) status_in = sale_pkg::ST_FULL;
            else ins_w = 1'b1;
         end
         sale_pkg::FUNC_INSERT: begin
            if (count_ff == sale_pkg::FULL_COUNT) status_in = sale_pkg::ST_FULL;
            else if (pos_x < cnt_x || pos_x == '0) begin
               ins_w  = 1'b1;
               cmd.at = pos_x;
            end else status_in = sale_pkg::ST_RANGE;
         end
         sale_pkg::FUNC_ERASE: begin
            if (pos_x >= cnt_x) status_in = sale_pkg::ST_RANGE;
            else begin
               del_w      = 1'b1;
               cmd.at     = pos_x;
               // the entry that slides into the slot is read before the shift
               cmd.rd_idx = pos_x + CMP_W'(1);
               cmd.rd_en  = (pos_x + CMP_W'(1)) < cnt_x;
               at_end_in  = (pos_x + CMP_W'(1)) == cnt_x;
            end
         end
         sale_pkg::FUNC_READ: begin
            if (pos_x >= cnt_x) status_in = sale_pkg::ST_RANGE;
            else cmd.rd_en = 1'b1;
         end
         default: ;
      endcase
      if (ins_w) count_in = count_ff + CNT_W'(1);
      if (del_w) count_in = count_ff - CNT_W'(1);
      cmd.ins = ins_w && fire;
      cmd.del = del_w && fire;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_w[i] = '0;
      end else begin : g_left
         assign left_w[i] = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_w[i] = '0;
      end else begin : g_right
         assign right_w[i] = cell_q[i+1];
      end

      sale_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .idx        (CMP_W'(i)),
         .left_data  (left_w[i]),
         .right_data (right_w[i]),
         .data_q     (cell_q[i]),
         .tap        (taps[i])
      );
   end

   // first level of the tap gather: OR within each group of cells
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         part_in[g] = '0;
         for (int k = 0; k < GRP_SIZE; k++) begin
            if (g * GRP_SIZE + k < DEPTH) part_in[g] = part_in[g] | taps[g * GRP_SIZE + k];
         end
      end
   end

   always_comb begin
      rsp_data_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         rsp_data_in = rsp_data_in | part_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) count_ff <= count_in;
         if (fire)         s1_valid_ff <= 1'b1;
         else if (s1_move) s1_valid_ff <= 1'b0;
         if (s1_move)      rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload stages: hold while the stage ahead is stalled
   always_ff @(posedge clock) begin
      if (fire) begin
         part_ff      <= part_in;
         s1_status_ff <= status_in;
         s1_count_ff  <= count_in;
         s1_at_end_ff <= at_end_in;
      end
      if (s1_move) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= s1_status_ff;
         rsp_count_ff  <= s1_count_ff;
         rsp_at_end_ff <= s1_at_end_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.data_out  = sale_pkg::to_dout(rsp_data_ff);
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.count_out = sale_pkg::to_count_out(rsp_count_ff);
   assign rsp_chan.at_end    = rsp_at_end_ff;

endmodule

/* hdl/sale_checker.sv */
// Port-level checks on the list engine response channel, bound to the top.
// Depends on sale_pkg and shift_array_list_engine_unit_defines.svh.
`timescale 1ns / 1ps
`include "shift_array_list_engine_unit_defines.svh"

module sale_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [sale_pkg::DOUT_W-1:0]      rsp_data_out,
   input logic [sale_pkg::STATUS_W-1:0]    rsp_status,
   input logic [sale_pkg::COUNT_OUT_W-1:0] rsp_count_out,
   input logic                            rsp_at_end
);

   `SALE_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out) && $stable(rsp_status) && $stable(rsp_count_out) && $stable(rsp_at_end), "response changed while stalled")
   `SALE_ASSERT_RST(a_reset_idle, reset |=> !rsp_valid, "response valid right after reset")
   `SALE_ASSERT(a_full_count, rsp_valid && rsp_status == sale_pkg::ST_FULL |-> rsp_count_out == sale_pkg::FULL_COUNT_OUT, "full status with list not full")
   `SALE_ASSERT(a_at_end, rsp_valid && rsp_at_end |-> rsp_status == sale_pkg::ST_OK && rsp_data_out == '0, "end flag with error or data")
   `SALE_ASSERT(a_err_quiet, rsp_valid && rsp_status != sale_pkg::ST_OK |-> rsp_data_out == '0 && !rsp_at_end, "error result carries data")

endmodule

bind shift_array_list_engine_unit sale_checker u_sale_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_data_out  (rsp_chan.data_out),
   .rsp_status    (rsp_chan.status),
   .rsp_count_out (rsp_chan.count_out),
   .rsp_at_end    (rsp_chan.at_end)
);
